### design/sensor_weighted_wavetable_bank_macros.svh
// ----------------------------------------------------------------------------
// sensor_weighted_wavetable_bank_macros
// Assertion helpers shared by the block's modules.
// ----------------------------------------------------------------------------
`ifndef SENSOR_WEIGHTED_WAVETABLE_BANK_MACROS_SVH
`define SENSOR_WEIGHTED_WAVETABLE_BANK_MACROS_SVH

// Clocked property, ignored while reset is held.
`define SWWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define SWWB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### design/swwb_pkg.sv
// ----------------------------------------------------------------------------
// swwb_pkg
// Types and constants of the sensor weighted wavetable bank.
// ----------------------------------------------------------------------------
package swwb_pkg;

  localparam int unsigned VOICES     = 1024;
  localparam int unsigned WAVE_DEPTH = 32768;  // power of two
  localparam int unsigned LEVEL_SHIFT = 16;

  localparam int unsigned VOICE_AW = $clog2(VOICES);
  localparam int unsigned VOICE_CW = $clog2(VOICES + 1);
  localparam int unsigned WAVE_AW  = $clog2(WAVE_DEPTH);
  localparam int unsigned SUM_W    = VOICE_AW + 16;
  localparam int unsigned PROD_W   = SUM_W + 16;
  localparam int unsigned DCNT_W   = $clog2(PROD_W + 1);

  localparam int unsigned CFG_IW = 1;
  localparam int unsigned CFG_DW = 16;

  typedef enum logic [1:0] {
    OP_WAVE   = 2'd0,
    OP_DESC   = 2'd1,
    OP_LEVEL  = 2'd2,
    OP_SAMPLE = 2'd3
  } op_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_THRESHOLD = 1'd0,
    CFG_VOICES    = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [14:0] target_index;
    logic [15:0] data_value;
    logic [14:0] area_start;
    logic [14:0] area_size;
    logic [14:0] phase_step;
  } in_t;

  typedef struct packed {
    logic [15:0] sample;
    logic [31:0] stereo_word;
  } out_t;

  typedef struct packed {
    logic                clr_en;
    logic                issue;
    logic [VOICE_AW-1:0] idx;
    logic                acc_clr;
    logic                wr_en;
    logic                div_start;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic                pipe_busy;
    logic                div_done;
    logic                out_free;
    logic [VOICE_CW-1:0] cnt_lim;
  } sts_t;

endpackage

### design/swwb_ctrl.sv
// ----------------------------------------------------------------------------
// swwb_ctrl
// Sequencer: memory clear after reset, write accept, voice scan, drain, divide, output.
// ----------------------------------------------------------------------------
`include "sensor_weighted_wavetable_bank_macros.svh"

module swwb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                is_sample_i,
  output logic                in_stall_o,
  input  swwb_pkg::sts_t      sts_i,
  output swwb_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_DRAIN, ST_DIV, ST_OUT
  } state_e;

  state_e                        state_q, state_d;
  logic [swwb_pkg::VOICE_CW-1:0] cnt_q, cnt_d;
  logic                          accept;
  logic [swwb_pkg::VOICE_CW-1:0] cnt_inc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign cnt_inc    = cnt_q + swwb_pkg::VOICE_CW'(1);

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    cmd_o            = '0;
    cmd_o.idx        = cnt_q[swwb_pkg::VOICE_AW-1:0];
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        cnt_d        = cnt_inc;
        if (cnt_q == swwb_pkg::VOICE_CW'(swwb_pkg::VOICES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_d = '0;
        if (accept && is_sample_i) begin
          cmd_o.acc_clr = 1'b1;
          state_d = (sts_i.cnt_lim == '0) ? ST_DRAIN : ST_SCAN;
        end else if (accept) begin
          cmd_o.wr_en = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        cnt_d       = cnt_inc;
        if (cnt_inc == sts_i.cnt_lim) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `SWWB_ASSERT(a_scan_in_range, (state_q == ST_SCAN) |-> (cnt_q < sts_i.cnt_lim), "scan past limit")
  `SWWB_ASSERT(a_div_after_drain, cmd_o.div_start |-> !sts_i.pipe_busy, "divide before drain")
  `SWWB_NEVER(a_clear_no_accept, (state_q == ST_CLEAR) && accept, "item taken during clear")

endmodule

### design/swwb_dp.sv
// ----------------------------------------------------------------------------
// swwb_dp
// Voice memories, scan pipeline, accumulators, divider and output register.
// ----------------------------------------------------------------------------
`include "sensor_weighted_wavetable_bank_macros.svh"

module swwb_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  swwb_pkg::in_t                     in_data_i,
  input  logic                              cfg_we_i,
  input  logic [swwb_pkg::CFG_IW-1:0]       cfg_idx_i,
  input  logic [swwb_pkg::CFG_DW-1:0]       cfg_wdata_i,
  input  swwb_pkg::cmd_t                    cmd_i,
  output swwb_pkg::sts_t                    sts_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output swwb_pkg::out_t                    out_data_o
);

  localparam int unsigned AW = swwb_pkg::VOICE_AW;
  localparam int unsigned CW = swwb_pkg::VOICE_CW;
  localparam int unsigned WW = swwb_pkg::WAVE_AW;
  localparam int unsigned SW = swwb_pkg::SUM_W;
  localparam int unsigned PW = swwb_pkg::PROD_W;
  localparam int unsigned NW = swwb_pkg::DCNT_W;

  logic [15:0] wave_mem  [swwb_pkg::WAVE_DEPTH];
  logic [44:0] desc_mem  [swwb_pkg::VOICES];
  logic [14:0] phase_mem [swwb_pkg::VOICES];
  logic [15:0] level_mem [swwb_pkg::VOICES];

  logic [15:0] thr_q;
  logic [10:0] vin_q;

  // stage 1: voice read
  logic          v1_q;
  logic [AW-1:0] idx1_q;
  logic [15:0]   lvl_rd_q;
  logic [44:0]   desc_rd_q;
  logic [14:0]   ph_rd_q;
  logic          act1;
  logic [15:0]   ph_sum, ph_wrap;
  logic [14:0]   ph_new;
  logic [WW-1:0] wave_addr;
  // stage 2: wave read
  logic          v2_q;
  logic [15:0]   lvl2_q;
  logic [15:0]   wave_rd_q;
  // stage 3: product
  logic          v3_q;
  logic [31:0]   prod_q;

  logic [SW-1:0] sum_q, lsum_q;
  logic [15:0]   max_q;

  logic [PW-1:0] num_q;
  logic [SW:0]   rem_q, rem_sh, rem_sub;
  logic [NW-1:0] dcnt_q;
  logic          drun_q, ddone_q;

  logic          out_valid_q;
  swwb_pkg::out_t out_q;
  logic [15:0]   result;

  logic wr_wave, wr_desc, wr_level, voice_ok, taken;

  assign voice_ok = (in_data_i.target_index < 15'(swwb_pkg::VOICES));
  assign wr_wave  = cmd_i.wr_en && (in_data_i.opcode == swwb_pkg::OP_WAVE) &&
                    (16'(in_data_i.target_index) < 16'(swwb_pkg::WAVE_DEPTH));
  assign wr_desc  = cmd_i.wr_en && (in_data_i.opcode == swwb_pkg::OP_DESC) && voice_ok;
  assign wr_level = cmd_i.wr_en && (in_data_i.opcode == swwb_pkg::OP_LEVEL) && voice_ok;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      vin_q <= 11'(swwb_pkg::VOICES);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swwb_pkg::CFG_THRESHOLD: thr_q <= cfg_wdata_i;
        swwb_pkg::CFG_VOICES:    vin_q <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  assign sts_o.cnt_lim = (vin_q > 11'(swwb_pkg::VOICES)) ? CW'(swwb_pkg::VOICES) : CW'(vin_q);

  // memories
  always_ff @(posedge clk_i) begin
    if (wr_wave) wave_mem[in_data_i.target_index[WW-1:0]] <= in_data_i.data_value;
    if (act1)    wave_rd_q <= wave_mem[wave_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_desc) begin
      desc_mem[in_data_i.target_index[AW-1:0]] <=
        {in_data_i.area_start, in_data_i.area_size, in_data_i.phase_step};
    end
    if (cmd_i.issue) desc_rd_q <= desc_mem[cmd_i.idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en)  level_mem[cmd_i.idx] <= '0;
    else if (wr_level) level_mem[in_data_i.target_index[AW-1:0]] <= in_data_i.data_value;
    if (cmd_i.issue)   lvl_rd_q <= level_mem[cmd_i.idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) phase_mem[cmd_i.idx] <= '0;
    else if (act1)    phase_mem[idx1_q] <= ph_new;
    if (cmd_i.issue)  ph_rd_q <= phase_mem[cmd_i.idx];
  end

  // phase advance and wrap
  assign act1      = v1_q && (lvl_rd_q > thr_q);
  assign ph_sum    = {1'b0, ph_rd_q} + {1'b0, desc_rd_q[14:0]};
  assign ph_wrap   = (ph_sum > {1'b0, desc_rd_q[29:15]}) ?
                     (ph_sum - {1'b0, desc_rd_q[29:15]}) : ph_sum;
  assign ph_new    = ph_wrap[14:0];
  assign wave_addr = WW'({1'b0, desc_rd_q[44:30]} + {1'b0, ph_new});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= act1;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= cmd_i.idx;
    lvl2_q <= lvl_rd_q;
    prod_q <= wave_rd_q * lvl2_q;
  end

  // accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      sum_q  <= '0;
      lsum_q <= '0;
      max_q  <= '0;
    end else begin
      if (act1) begin
        lsum_q <= lsum_q + SW'(lvl_rd_q);
        if (lvl_rd_q > max_q) max_q <= lvl_rd_q;
      end
      if (v3_q) sum_q <= sum_q + SW'(prod_q[31:swwb_pkg::LEVEL_SHIFT]);
    end
  end

  assign sts_o.pipe_busy = v1_q || v2_q || v3_q;

  // restoring divider, one quotient bit a cycle
  assign rem_sh  = {rem_q[SW-1:0], num_q[PW-1]};
  assign rem_sub = rem_sh - {1'b0, lsum_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drun_q  <= 1'b0;
      ddone_q <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      ddone_q <= 1'b0;
      if (cmd_i.div_start) begin
        drun_q <= 1'b1;
        dcnt_q <= NW'(PW);
      end else if (drun_q) begin
        dcnt_q <= dcnt_q - NW'(1);
        if (dcnt_q == NW'(1)) begin
          drun_q  <= 1'b0;
          ddone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q <= sum_q * max_q;
      rem_q <= '0;
    end else if (drun_q) begin
      if (rem_sh >= {1'b0, lsum_q}) begin
        rem_q <= rem_sub;
        num_q <= {num_q[PW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[PW-2:0], 1'b0};
      end
    end
  end

  assign sts_o.div_done = ddone_q;

  // output register
  assign result         = (lsum_q == '0) ? 16'd0 : num_q[15:0];
  assign taken          = out_valid_q && !out_stall_i;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (taken) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.sample      <= result;
      out_q.stereo_word <= {result, result};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SWWB_ASSERT(a_no_overwrite, cmd_i.out_load |-> (!out_valid_q || !out_stall_i), "result lost")
  `SWWB_NEVER(a_div_while_scan, drun_q && sts_o.pipe_busy, "divide while scanning")
  `SWWB_ASSERT(a_done_once, ddone_q |=> !ddone_q, "divider done twice")

endmodule

### design/sensor_weighted_wavetable_bank.sv
// ----------------------------------------------------------------------------
// sensor_weighted_wavetable_bank
// Additive wavetable bank with one voice per sensor pixel.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one item a beat
// while idle: wave word, voice descriptor, sensor level writes, or a
// make-sample request. A make-sample scans N = min(voices_in_use, 1024)
// voices through the voice-read, wave-read and product pipeline stages,
// one voice a cycle, then multiplies and runs a restoring divider.
// The result beat appears on out_valid_o / out_data_o and sits in an output
// register; the input side accepts again as soon as it is loaded there.
// If the receiver stalls, the next sample waits in the divider until the
// output register frees.
// After reset a clearing pass zeroes voice phases and levels with
// in_stall_o high; configuration writes are taken throughout.
// Configuration: cfg_we_i with cfg_idx_i 0 = level threshold,
// 1 = voices in use; write only while the block is idle.
// ----------------------------------------------------------------------------
module sensor_weighted_wavetable_bank (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  swwb_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output swwb_pkg::out_t              out_data_o,
  input  logic                        cfg_we_i,
  input  logic [swwb_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [swwb_pkg::CFG_DW-1:0] cfg_wdata_i
);

  swwb_pkg::cmd_t cmd;
  swwb_pkg::sts_t sts;

  swwb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .is_sample_i (in_data_i.opcode == swwb_pkg::OP_SAMPLE),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swwb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
